// ===== src/nis_pkg.sv =====
// ----------------------------------------------------------------------------
// nis_pkg
// Shared types and constants of the non-preemptive interrupt scheduler.
// ----------------------------------------------------------------------------
package nis_pkg;

  localparam int NUM_IRQ     = 8;
  localparam int PRIO_BITS   = 4;
  localparam int TIME_BITS   = 32;
  localparam int RUN_BITS    = 8;
  localparam int ID_BITS     = 3;
  localparam int MISS_BITS   = 32;
  localparam int OUT_BITS    = 32;
  localparam int PRIO_TBL_W  = 32;
  localparam int RUN_TBL_W   = 64;
  localparam int APB_DATA_W  = 64;
  localparam int APB_ADDR_W  = 4;

  // register index, taken from paddr[3]
  localparam logic REG_PRIORITY = 1'b0;
  localparam logic REG_RUN_TIME = 1'b1;

  typedef logic [NUM_IRQ-1:0]    irq_mask_t;
  typedef logic [ID_BITS-1:0]    irq_id_t;
  typedef logic [PRIO_BITS-1:0]  prio_t;
  typedef logic [RUN_BITS-1:0]   run_t;
  typedef logic [TIME_BITS-1:0]  tick_t;
  typedef logic [MISS_BITS-1:0]  miss_cnt_t;
  typedef logic [OUT_BITS-1:0]   lat_t;

  typedef struct packed {
    logic [PRIO_TBL_W-1:0] priority_table;
    logic [RUN_TBL_W-1:0]  run_time_table;
  } nis_cfg_t;

  typedef struct packed {
    logic      done_res;
    irq_id_t   done_id;
    lat_t      latency;
    lat_t      done_max_latency;
    irq_mask_t missed_mask;
    logic      running_valid;
    irq_id_t   running_id;
  } nis_result_t;

endpackage

// ===== src/nis_if.sv =====
// ----------------------------------------------------------------------------
// nis_in_if / nis_out_if
// Valid/ready channels for trigger masks and scheduler results.
// ----------------------------------------------------------------------------
interface nis_in_if;
  logic                 valid;
  logic                 ready;
  nis_pkg::irq_mask_t   trigger_mask;

  modport source (output valid, output trigger_mask, input ready);
  modport sink   (input valid, input trigger_mask, output ready);
endinterface

interface nis_out_if;
  logic                 valid;
  logic                 ready;
  logic                 done_res;
  nis_pkg::irq_id_t     done_id;
  nis_pkg::lat_t        latency;
  nis_pkg::lat_t        done_max_latency;
  nis_pkg::irq_mask_t   missed_mask;
  logic                 running_valid;
  nis_pkg::irq_id_t     running_id;

  modport source (output valid, output done_res, output done_id, output latency,
                  output done_max_latency, output missed_mask,
                  output running_valid, output running_id, input ready);
  modport sink   (input valid, input done_res, input done_id, input latency,
                  input done_max_latency, input missed_mask,
                  input running_valid, input running_id, output ready);
endinterface

// ===== src/nonpreemptive_interrupt_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// nonpreemptive_interrupt_scheduler_top
// Path: a trigger mask is held in the input register and its result in the
// result register, from which it is offered on the output channel.
// Throughput: one trigger mask per cycle while the output channel is ready;
// the tick update between the input register and the result register is
// combinational. Reset: synchronous, active low; clears all scheduler state
// and both tables. Configuration: APB registers priority_table at 0x0,
// run_time_table at 0x8.
module nonpreemptive_interrupt_scheduler_top (
  input  logic                               clk,
  input  logic                               rst_n,
  nis_in_if.sink                             in_chan,
  nis_out_if.source                          out_chan,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [nis_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [nis_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [nis_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import nis_pkg::*;

  nis_cfg_t    cfg_r;
  logic        s1_valid_r;
  irq_mask_t   s1_mask_r;
  logic        out_valid_r;
  nis_result_t out_r;
  nis_result_t res;
  logic        advance;
  logic        reg_sel;

  assign reg_sel = paddr[3];
  assign pready  = 1'b1;
  assign prdata  = (reg_sel == REG_RUN_TIME) ? cfg_r.run_time_table
                                             : APB_DATA_W'(cfg_r.priority_table);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_PRIORITY: cfg_r.priority_table <= pwdata[PRIO_TBL_W-1:0];
        REG_RUN_TIME: cfg_r.run_time_table <= pwdata[RUN_TBL_W-1:0];
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  assign advance       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || advance;

  nis_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .trigger_mask (s1_mask_r),
    .cfg          (cfg_r),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_mask_r <= in_chan.trigger_mask;
    end
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.done_res         = out_r.done_res;
  assign out_chan.done_id          = out_r.done_id;
  assign out_chan.latency          = out_r.latency;
  assign out_chan.done_max_latency = out_r.done_max_latency;
  assign out_chan.missed_mask      = out_r.missed_mask;
  assign out_chan.running_valid    = out_r.running_valid;
  assign out_chan.running_id       = out_r.running_id;

endmodule

// ===== src/nis_core.sv =====
// ----------------------------------------------------------------------------
// nis_core
// Scheduler state and the single-tick update: pending capture, priority
// selection, completion check and latency bookkeeping.
// ----------------------------------------------------------------------------
module nis_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  nis_pkg::irq_mask_t   trigger_mask,
  input  nis_pkg::nis_cfg_t    cfg,
  output nis_pkg::nis_result_t res
);
  import nis_pkg::*;

  tick_t     tick_r,  tick_nxt;
  logic      busy_r,  busy_nxt;
  irq_id_t   cur_id_r, cur_id_nxt;
  tick_t     cur_start_r, cur_start_nxt;
  tick_t     cur_arr_r, cur_arr_nxt;
  irq_mask_t pend_r,  pend_nxt;
  tick_t     pend_arr_r [NUM_IRQ];
  tick_t     pend_arr_nxt [NUM_IRQ];
  miss_cnt_t miss_r [NUM_IRQ];
  miss_cnt_t miss_nxt [NUM_IRQ];
  tick_t     worst_r [NUM_IRQ];
  tick_t     worst_nxt [NUM_IRQ];

  always_comb begin
    irq_mask_t missed;
    irq_mask_t pend_cap;
    irq_mask_t demote;
    logic      found;
    irq_id_t   best;
    prio_t     bprio;
    prio_t     p;
    run_t      run_cur;
    tick_t     elapsed;
    tick_t     lat;
    tick_t     worst_upd;
    logic      finish;

    missed   = trigger_mask & pend_r;
    tick_nxt = tick_r + tick_t'(1);
    busy_nxt = busy_r;
    cur_id_nxt    = cur_id_r;
    cur_start_nxt = cur_start_r;
    cur_arr_nxt   = cur_arr_r;
    pend_nxt      = pend_r;
    pend_arr_nxt  = pend_arr_r;
    worst_nxt     = worst_r;
    demote  = '0;
    found   = 1'b0;
    best    = '0;
    bprio   = '0;
    finish  = 1'b0;
    lat     = '0;
    worst_upd = '0;

    for (int i = 0; i < NUM_IRQ; i++) begin
      miss_nxt[i] = (missed[i] && miss_r[i] != '1) ? miss_r[i] + miss_cnt_t'(1) : miss_r[i];
    end

    pend_cap = pend_r | trigger_mask;
    run_cur  = cfg.run_time_table[RUN_BITS*cur_id_r +: RUN_BITS];
    elapsed  = tick_r - cur_start_r;
    lat      = tick_r - cur_arr_r;
    worst_upd = (lat > worst_r[cur_id_r]) ? lat : worst_r[cur_id_r];

    if (busy_r) begin
      for (int i = 0; i < NUM_IRQ; i++) begin
        p = cfg.priority_table[PRIO_BITS*i +: PRIO_BITS];
        if (trigger_mask[i] && !pend_r[i]) begin
          pend_arr_nxt[i] = tick_r;
        end
        if (pend_cap[i] && p > bprio) begin
          found = 1'b1;
          best  = irq_id_t'(i);
          bprio = p;
        end
      end
      pend_nxt = pend_cap;
      finish   = (tick_t'(run_cur) <= elapsed);
      if (finish) begin
        busy_nxt = found;
        worst_nxt[cur_id_r] = worst_upd;
        if (found) begin
          cur_id_nxt    = best;
          cur_start_nxt = tick_r;
          pend_nxt[best] = 1'b0;
          cur_arr_nxt   = pend_arr_nxt[best];
        end
      end
    end else begin
      for (int i = 0; i < NUM_IRQ; i++) begin
        p = cfg.priority_table[PRIO_BITS*i +: PRIO_BITS];
        if (trigger_mask[i] && p > bprio) begin
          if (found) begin
            demote[best] = 1'b1;
          end
          found = 1'b1;
          best  = irq_id_t'(i);
          bprio = p;
        end
      end
      pend_nxt = pend_r | demote;
      for (int i = 0; i < NUM_IRQ; i++) begin
        if (demote[i]) begin
          pend_arr_nxt[i] = tick_r;
        end
      end
      if (found) begin
        busy_nxt      = 1'b1;
        cur_id_nxt    = best;
        cur_start_nxt = tick_r;
        cur_arr_nxt   = tick_r;
      end
    end

    res.done_res         = finish;
    res.done_id          = finish ? cur_id_r : '0;
    res.latency          = finish ? lat_t'(lat) : '0;
    res.done_max_latency = finish ? lat_t'(worst_upd) : '0;
    res.missed_mask      = missed;
    res.running_valid    = busy_nxt;
    res.running_id       = busy_nxt ? cur_id_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= '0;
      busy_r      <= 1'b0;
      cur_id_r    <= '0;
      cur_start_r <= '0;
      cur_arr_r   <= '0;
      pend_r      <= '0;
      for (int i = 0; i < NUM_IRQ; i++) begin
        pend_arr_r[i] <= '0;
        miss_r[i]     <= '0;
        worst_r[i]    <= '0;
      end
    end else if (step) begin
      tick_r      <= tick_nxt;
      busy_r      <= busy_nxt;
      cur_id_r    <= cur_id_nxt;
      cur_start_r <= cur_start_nxt;
      cur_arr_r   <= cur_arr_nxt;
      pend_r      <= pend_nxt;
      pend_arr_r  <= pend_arr_nxt;
      miss_r      <= miss_nxt;
      worst_r     <= worst_nxt;
    end
  end

endmodule

// ===== tb/sv/nonpreemptive_interrupt_scheduler_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonpreemptive_interrupt_scheduler_top_test
// Drives trigger masks tick by tick into the scheduler and checks every
// result against an in-bench scheduler that tracks the running line,
// pending lines, arrival stamps and worst latencies. Tables are programmed
// over APB between phases and read back. Directed ticks cover arbitration
// ties, priority zero, zero run time, demotion on an idle start, missed
// requests and promotion of a long-pending line. Randomised phases follow,
// with bursty input, receiver stalls and a long output hold-off.
// ----------------------------------------------------------------------------
module nonpreemptive_interrupt_scheduler_top_test;
  import nis_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 11;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int REPORT_LIMIT  = 10;

  localparam logic [APB_ADDR_W-1:0] PRIO_ADDR = {REG_PRIORITY, 3'b000};
  localparam logic [APB_ADDR_W-1:0] RUN_ADDR  = {REG_RUN_TIME, 3'b000};

  typedef enum int {STALL_NONE, STALL_PATTERN, STALL_RANDOM} stall_mode_e;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  nis_in_if  trig_chan ();
  nis_out_if sched_chan ();

  nonpreemptive_interrupt_scheduler_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (trig_chan),
    .out_chan (sched_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #CLK_HALF clk = ~clk;

  // scheduler state as seen from the tables and the accepted ticks
  logic [PRIO_TBL_W-1:0] prio_cfg = '0;
  logic [RUN_TBL_W-1:0]  run_cfg = '0;
  tick_t                 sched_tick = '0;
  logic                  cur_busy = 1'b0;
  irq_id_t               cur_id = '0;
  tick_t                 cur_start = '0;
  tick_t                 cur_arrival = '0;
  irq_mask_t             pend_flags = '0;
  tick_t                 pend_stamp [NUM_IRQ] = '{default: '0};
  lat_t                  worst_lat [NUM_IRQ] = '{default: '0};
  nis_result_t           tick_outcomes [$];

  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned completions = 0;
  int unsigned missed_bits = 0;
  int unsigned reg_writes = 0;
  int unsigned mismatches = 0;
  int unsigned stray_results = 0;
  int unsigned cycle_count = 0;

  int          hold_left = 0;
  stall_mode_e stall_mode = STALL_NONE;
  logic [15:0] stall_pat = 16'hB5E7;

  function automatic prio_t prio_of_line(int i);
    return prio_cfg[PRIO_BITS*i +: PRIO_BITS];
  endfunction

  function automatic run_t run_of_line(int i);
    return run_cfg[RUN_BITS*i +: RUN_BITS];
  endfunction

  function automatic nis_result_t advance_scheduler(irq_mask_t trig);
    nis_result_t r;
    logic        found;
    int          best;
    prio_t       best_prio;
    lat_t        lat;
    r = '0;
    found = 1'b0;
    best = 0;
    best_prio = '0;
    r.missed_mask = trig & pend_flags;
    if (cur_busy) begin
      for (int i = 0; i < NUM_IRQ; i++) begin
        if (trig[i] && !pend_flags[i]) begin
          pend_flags[i] = 1'b1;
          pend_stamp[i] = sched_tick;
        end
      end
      for (int i = 0; i < NUM_IRQ; i++) begin
        if (pend_flags[i] && prio_of_line(i) > best_prio) begin
          found = 1'b1;
          best = i;
          best_prio = prio_of_line(i);
        end
      end
      if (tick_t'(run_of_line(cur_id)) <= tick_t'(sched_tick - cur_start)) begin
        cur_busy = 1'b0;
        lat = sched_tick - cur_arrival;
        if (lat > worst_lat[cur_id]) worst_lat[cur_id] = lat;
        r.done_res = 1'b1;
        r.done_id = cur_id;
        r.latency = lat;
        r.done_max_latency = worst_lat[cur_id];
        if (found) begin
          cur_busy = 1'b1;
          cur_id = irq_id_t'(best);
          cur_start = sched_tick;
          pend_flags[best] = 1'b0;
          cur_arrival = pend_stamp[best];
        end
      end
    end else begin
      for (int i = 0; i < NUM_IRQ; i++) begin
        if (trig[i] && prio_of_line(i) > best_prio) begin
          // demote the previous winner of the scan
          if (found) begin
            pend_flags[best] = 1'b1;
            pend_stamp[best] = sched_tick;
          end
          found = 1'b1;
          best = i;
          best_prio = prio_of_line(i);
        end
      end
      if (found) begin
        cur_busy = 1'b1;
        cur_id = irq_id_t'(best);
        cur_start = sched_tick;
        cur_arrival = sched_tick;
      end
    end
    sched_tick = sched_tick + 1'b1;
    r.running_valid = cur_busy;
    r.running_id = cur_busy ? cur_id : '0;
    return r;
  endfunction

  function automatic irq_mask_t random_trigger();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return '0;
    if (pick < 7) return irq_mask_t'(1) << $urandom_range(0, NUM_IRQ - 1);
    return irq_mask_t'($urandom);
  endfunction

  function automatic logic [PRIO_TBL_W-1:0] random_priorities();
    logic [PRIO_TBL_W-1:0] v;
    v = PRIO_TBL_W'($urandom);
    for (int i = 0; i < NUM_IRQ; i++) begin
      if ($urandom_range(0, 3) == 0) v[PRIO_BITS*i +: PRIO_BITS] = '0;
    end
    return v;
  endfunction

  function automatic logic [RUN_TBL_W-1:0] random_run_times(int unsigned longest);
    logic [RUN_TBL_W-1:0] v;
    v = '0;
    for (int i = 0; i < NUM_IRQ; i++) begin
      v[RUN_BITS*i +: RUN_BITS] = RUN_BITS'($urandom_range(0, longest));
    end
    return v;
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    end
  endtask

  // one tick: hold valid until the transfer, then predict its result
  task automatic send_trigger(input irq_mask_t mask);
    trig_chan.valid <= 1'b1;
    trig_chan.trigger_mask <= mask;
    @(posedge clk);
    while (!trig_chan.ready) @(posedge clk);
    tick_outcomes.push_back(advance_scheduler(mask));
    items_sent++;
  endtask

  task automatic hold_input(input int cycles);
    trig_chan.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic send_burst_traffic(input int count);
    int burst;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        if ($urandom_range(0, 2) != 0) hold_input($urandom_range(1, 6));
      end
      send_trigger(random_trigger());
      burst--;
    end
  endtask

  task automatic settle();
    trig_chan.valid <= 1'b0;
    while (tick_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write, then read back the same register
  task automatic write_register(input logic [APB_ADDR_W-1:0] addr,
                                input logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] readback;
    logic [APB_DATA_W-1:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == PRIO_ADDR) prio_cfg = value[PRIO_TBL_W-1:0];
    else run_cfg = value;
    reg_writes++;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (addr == PRIO_ADDR) begin
      readback = APB_DATA_W'(readback[PRIO_TBL_W-1:0]);
      want = APB_DATA_W'(prio_cfg);
    end else begin
      want = run_cfg;
    end
    if (readback !== want) note_mismatch("register readback", want, readback);
  endtask

  task automatic send_mask_list(input irq_mask_t masks [$]);
    foreach (masks[k]) send_trigger(masks[k]);
  endtask

  task automatic test_reset_state();
    stall_mode = STALL_NONE;
    send_mask_list('{8'h00, 8'hFF, 8'h01, 8'h80});
    settle();
  endtask

  task automatic test_priority_rules();
    stall_mode = STALL_PATTERN;
    write_register(PRIO_ADDR, 64'hDEAD_BEEF_F01F_2F30);
    write_register(RUN_ADDR, 64'hFF00_0205_0103_0004);
    send_mask_list('{8'hFF, 8'h02, 8'h01, 8'h00, 8'h00, 8'h01, 8'h18,
                     8'h08, 8'h40, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00});
    settle();
  endtask

  task automatic test_pending_promotion();
    stall_mode = STALL_RANDOM;
    write_register(PRIO_ADDR, 64'h0000_0000_F01F_2F3F);
    write_register(RUN_ADDR, 64'h0000_0205_0103_0004);
    send_mask_list('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00});
    settle();
  endtask

  task automatic test_random_schedules();
    stall_mode = STALL_PATTERN;
    write_register(PRIO_ADDR, APB_DATA_W'($urandom));
    write_register(RUN_ADDR, random_run_times(6));
    send_burst_traffic(250);
    settle();

    stall_mode = STALL_RANDOM;
    write_register(PRIO_ADDR, 64'hFFFF_FFFF_FFFF_FFFF);
    write_register(RUN_ADDR, '0);
    send_burst_traffic(200);
    settle();

    stall_mode = STALL_NONE;
    write_register(PRIO_ADDR, APB_DATA_W'(random_priorities()));
    write_register(RUN_ADDR, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int n = 0; n < 60; n++) send_trigger(random_trigger());
    send_burst_traffic(60);
    settle();

    stall_mode = STALL_PATTERN;
    write_register(PRIO_ADDR, '0);
    send_burst_traffic(60);
    settle();
  endtask

  task automatic test_drain_pause();
    stall_mode = STALL_RANDOM;
    write_register(PRIO_ADDR, APB_DATA_W'(random_priorities()));
    write_register(RUN_ADDR, random_run_times(3));
    send_burst_traffic(130);
    settle();
    send_burst_traffic(130);
    settle();
  endtask

  task automatic test_output_backpressure();
    stall_mode = STALL_NONE;
    write_register(PRIO_ADDR, APB_DATA_W'(random_priorities()));
    write_register(RUN_ADDR, random_run_times(4));
    hold_left = 400;
    for (int n = 0; n < 120; n++) send_trigger(random_trigger());
    settle();
  endtask

  always @(posedge clk) begin
    stall_pat = {stall_pat[0], stall_pat[15:1]};
    if ($urandom_range(0, 99) == 0) stall_pat = 16'($urandom) | 16'h0101;
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      sched_chan.ready <= 1'b0;
    end else begin
      case (stall_mode)
        STALL_NONE: begin
          sched_chan.ready <= 1'b1;
        end
        STALL_PATTERN: begin
          sched_chan.ready <= stall_pat[0];
        end
        default: begin
          sched_chan.ready <= ($urandom_range(0, 3) != 0);
        end
      endcase
    end
  end

  always @(posedge clk) begin : check_outcomes
    nis_result_t want;
    if (rst_n && sched_chan.valid && sched_chan.ready) begin
      results_seen++;
      if (tick_outcomes.size() == 0) begin
        stray_results++;
        if (stray_results <= REPORT_LIMIT) $display("result transfer with no tick waiting");
      end else begin
        want = tick_outcomes.pop_front();
        completions += want.done_res;
        missed_bits += $countones(want.missed_mask);
        if (sched_chan.done_res !== want.done_res)
          note_mismatch("done_res", want.done_res, sched_chan.done_res);
        if (sched_chan.done_id !== want.done_id)
          note_mismatch("done_id", want.done_id, sched_chan.done_id);
        if (sched_chan.latency !== want.latency)
          note_mismatch("latency", want.latency, sched_chan.latency);
        if (sched_chan.done_max_latency !== want.done_max_latency)
          note_mismatch("done_max_latency", want.done_max_latency,
                        sched_chan.done_max_latency);
        if (sched_chan.missed_mask !== want.missed_mask)
          note_mismatch("missed_mask", want.missed_mask, sched_chan.missed_mask);
        if (sched_chan.running_valid !== want.running_valid)
          note_mismatch("running_valid", want.running_valid, sched_chan.running_valid);
        if (sched_chan.running_id !== want.running_id)
          note_mismatch("running_id", want.running_id, sched_chan.running_id);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("nonpreemptive_interrupt_scheduler_top_test: FAIL");
    $finish;
  end

  initial begin : run_tests
    int unsigned failures;
    rst_n <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    trig_chan.valid <= 1'b0;
    trig_chan.trigger_mask <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_priority_rules();
    test_pending_promotion();
    test_random_schedules();
    test_drain_pause();
    test_output_backpressure();
    settle();

    failures = mismatches + stray_results + tick_outcomes.size();
    $display("ticks sent %0d, results checked %0d, completions %0d, missed requests %0d",
             items_sent, results_seen, completions, missed_bits);
    $display("register writes %0d, mismatches %0d, unexpected results %0d",
             reg_writes, mismatches, stray_results);
    if (failures == 0) begin
      $display("nonpreemptive_interrupt_scheduler_top_test: PASS");
    end else begin
      $display("nonpreemptive_interrupt_scheduler_top_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/nis_pkg.sv
src/nis_if.sv
src/nis_core.sv
src/nonpreemptive_interrupt_scheduler_top.sv
tb/sv/nonpreemptive_interrupt_scheduler_top_test.sv
